FILE: src/one_wire_bus_master_unit_defines.svh
// ----------------------------------------------------------------------------
// One-wire bus master assertion macros
// Shared property shapes for the checker of the one-wire bus master.
// ----------------------------------------------------------------------------
`ifndef ONE_WIRE_BUS_MASTER_UNIT_DEFINES_SVH
`define ONE_WIRE_BUS_MASTER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define OWM_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("one-wire master check failed");

// Next-cycle implication, disabled while reset is asserted.
`define OWM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("one-wire master check failed");

// Next-cycle implication that is also checked across reset.
`define OWM_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("one-wire master check failed");

`endif

FILE: src/owm_pkg.sv
// ----------------------------------------------------------------------------
// One-wire bus master package
// Types, codes and reset values shared by the one-wire bus master files.
// ----------------------------------------------------------------------------
package owm_pkg;

  localparam int unsigned BitsPerByte = 8;
  localparam int unsigned CfgIdxW     = 3;
  localparam int unsigned CfgDataW    = 16;

  localparam logic [CfgIdxW-1:0] CFG_RESET_LOW    = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_PRES_WINDOW  = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_POST_RESET   = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_SLOT_LOW     = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_SAMPLE_DELAY = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_SLOT_LENGTH  = 3'd5;
  localparam logic [CfgIdxW-1:0] CFG_RECOVERY     = 3'd6;

  localparam logic [15:0] RST_RESET_LOW    = 16'd500;
  localparam logic [15:0] RST_PRES_WINDOW  = 16'd240;
  localparam logic [15:0] RST_POST_RESET   = 16'd500;
  localparam logic [7:0]  RST_SLOT_LOW     = 8'd1;
  localparam logic [7:0]  RST_SAMPLE_DELAY = 8'd6;
  localparam logic [7:0]  RST_SLOT_LENGTH  = 8'd65;
  localparam logic [7:0]  RST_RECOVERY     = 8'd2;

  localparam logic [1:0] OP_RESET = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  localparam logic [2:0] PH_IDLE     = 3'd0;
  localparam logic [2:0] PH_RST_LOW  = 3'd1;
  localparam logic [2:0] PH_RST_WIN  = 3'd2;
  localparam logic [2:0] PH_RST_REC  = 3'd3;
  localparam logic [2:0] PH_SLOT     = 3'd4;
  localparam logic [2:0] PH_SLOT_REC = 3'd5;

  typedef struct packed {
    logic [15:0] reset_low_ticks;
    logic [15:0] presence_window_ticks;
    logic [15:0] post_reset_ticks;
    logic [7:0]  slot_low_ticks;
    logic [7:0]  sample_delay_ticks;
    logic [7:0]  slot_length_ticks;
    logic [7:0]  recovery_ticks;
  } cfg_t;

  typedef struct packed {
    logic       drive_low;
    logic       busy_res;
    logic       done_res;
    logic       presence;
    logic [7:0] read_data;
  } res_t;

  function automatic logic [15:0] at_least_one16(input logic [15:0] v);
    return (v == 16'd0) ? 16'd1 : v;
  endfunction

  function automatic logic [7:0] at_least_one8(input logic [7:0] v);
    return (v == 8'd0) ? 8'd1 : v;
  endfunction

endpackage

FILE: src/owm_core.sv
// ----------------------------------------------------------------------------
// One-wire bus master sequencer
// Holds the operation state and advances it by one bus tick per transfer.
// ----------------------------------------------------------------------------
module owm_core (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          step,
  input  logic          start_req,
  input  logic [1:0]    operation,
  input  logic [7:0]    write_data,
  input  logic          line_sample,
  input  owm_pkg::cfg_t cfg,
  output owm_pkg::res_t res
);
  import owm_pkg::*;

  logic [2:0]  phase_r, phase_nxt;
  logic [1:0]  cur_op_r, cur_op_nxt;
  logic [15:0] tick_r, tick_nxt;
  logic [3:0]  bits_r, bits_nxt;
  logic [7:0]  shift_r, shift_nxt;
  logic        pres_r, pres_nxt;
  logic [7:0]  last_read_r, last_read_nxt;

  logic [16:0] next_cnt;
  logic [7:0]  slot_len;
  logic [7:0]  slot_low;
  logic [8:0]  sample_pt;
  logic [8:0]  sample_lim;
  logic [8:0]  sample_at;
  logic [7:0]  shift_tmp;
  logic [3:0]  bits_inc;
  logic        drive;
  logic        busy;
  logic        done;

  assign next_cnt   = {1'b0, tick_r} + 17'd1;
  assign slot_len   = at_least_one8(cfg.slot_length_ticks);
  assign slot_low   = at_least_one8(cfg.slot_low_ticks);
  assign sample_pt  = {1'b0, slot_low} + {1'b0, cfg.sample_delay_ticks};
  assign sample_lim = {1'b0, slot_len} - 9'd1;
  assign sample_at  = (sample_pt > sample_lim) ? sample_lim : sample_pt;
  assign bits_inc   = bits_r + 4'd1;

  always_comb begin
    phase_nxt     = phase_r;
    cur_op_nxt    = cur_op_r;
    tick_nxt      = tick_r;
    bits_nxt      = bits_r;
    shift_nxt     = shift_r;
    pres_nxt      = pres_r;
    last_read_nxt = last_read_r;
    shift_tmp     = shift_r;
    drive         = 1'b0;
    busy          = 1'b0;
    done          = 1'b0;
    case (phase_r)
      PH_IDLE: begin
        if (start_req) begin
          if (operation == OP_RESET) begin
            cur_op_nxt = OP_RESET;
            pres_nxt   = 1'b0;
            tick_nxt   = 16'd0;
            phase_nxt  = PH_RST_LOW;
          end else if (operation == OP_WRITE || operation == OP_READ) begin
            cur_op_nxt = operation;
            shift_nxt  = (operation == OP_WRITE) ? write_data : 8'd0;
            bits_nxt   = 4'd0;
            tick_nxt   = 16'd0;
            phase_nxt  = PH_SLOT;
          end
        end
      end
      PH_RST_LOW: begin
        drive = 1'b1;
        busy  = 1'b1;
        if (next_cnt >= {1'b0, at_least_one16(cfg.reset_low_ticks)}) begin
          tick_nxt  = 16'd0;
          phase_nxt = PH_RST_WIN;
        end else begin
          tick_nxt = next_cnt[15:0];
        end
      end
      PH_RST_WIN: begin
        busy = 1'b1;
        if (!line_sample) begin
          pres_nxt = 1'b1;
        end
        if (next_cnt >= {1'b0, at_least_one16(cfg.presence_window_ticks)}) begin
          tick_nxt = 16'd0;
          if (cfg.post_reset_ticks == 16'd0) begin
            phase_nxt = PH_IDLE;
            done      = 1'b1;
          end else begin
            phase_nxt = PH_RST_REC;
          end
        end else begin
          tick_nxt = next_cnt[15:0];
        end
      end
      PH_RST_REC: begin
        busy = 1'b1;
        if (next_cnt >= {1'b0, cfg.post_reset_ticks}) begin
          tick_nxt  = 16'd0;
          phase_nxt = PH_IDLE;
          done      = 1'b1;
        end else begin
          tick_nxt = next_cnt[15:0];
        end
      end
      PH_SLOT: begin
        busy  = 1'b1;
        drive = (tick_r < {8'd0, slot_low}) || (cur_op_r == OP_WRITE && !shift_r[0]);
        if (cur_op_r == OP_READ && tick_r == {7'd0, sample_at}) begin
          shift_tmp = {line_sample, shift_r[7:1]};
        end
        shift_nxt = shift_tmp;
        if (next_cnt >= {9'd0, slot_len}) begin
          if (cur_op_r == OP_WRITE) begin
            shift_nxt = {1'b0, shift_tmp[7:1]};
          end
          bits_nxt = bits_inc;
          tick_nxt = 16'd0;
          if (bits_inc >= 4'(BitsPerByte)) begin
            if (cur_op_r == OP_READ) begin
              last_read_nxt = shift_tmp;
            end
            phase_nxt = PH_IDLE;
            done      = 1'b1;
          end else if (cfg.recovery_ticks != 8'd0) begin
            phase_nxt = PH_SLOT_REC;
          end
        end else begin
          tick_nxt = next_cnt[15:0];
        end
      end
      PH_SLOT_REC: begin
        busy = 1'b1;
        if (next_cnt >= {9'd0, cfg.recovery_ticks}) begin
          tick_nxt  = 16'd0;
          phase_nxt = PH_SLOT;
        end else begin
          tick_nxt = next_cnt[15:0];
        end
      end
      default: begin
        phase_nxt = PH_IDLE;
        tick_nxt  = 16'd0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      cur_op_r    <= OP_RESET;
      tick_r      <= 16'd0;
      bits_r      <= 4'd0;
      shift_r     <= 8'd0;
      pres_r      <= 1'b0;
      last_read_r <= 8'd0;
    end else if (step) begin
      phase_r     <= phase_nxt;
      cur_op_r    <= cur_op_nxt;
      tick_r      <= tick_nxt;
      bits_r      <= bits_nxt;
      shift_r     <= shift_nxt;
      pres_r      <= pres_nxt;
      last_read_r <= last_read_nxt;
    end
  end

  always_comb begin
    res.drive_low = drive;
    res.busy_res  = busy;
    res.done_res  = done;
    res.presence  = pres_nxt;
    res.read_data = last_read_nxt;
  end

endmodule

FILE: src/one_wire_bus_master_unit.sv
// ----------------------------------------------------------------------------
// One-wire bus master unit
// Tick-driven one-wire master with configurable timing and a buffered result.
// ----------------------------------------------------------------------------
// Each input transfer is one bus tick and yields exactly one result transfer.
// A tick is taken whenever in_valid is high and in_stall is low. Its result
// is registered in the output register, or in the skid register while the
// output register waits. The sequencer advances once per tick, at a rate of
// one tick per cycle while in_stall is low; the two-entry output stage lets
// input flow while a result waits; in_stall rises only once both are full.
module one_wire_bus_master_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [owm_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [owm_pkg::CfgDataW-1:0]  cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_start_req,
  input  logic [1:0]                    in_operation,
  input  logic [7:0]                    in_write_data,
  input  logic                          in_line_sample,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_drive_low,
  output logic                          out_busy_res,
  output logic                          out_done_res,
  output logic                          out_presence,
  output logic [7:0]                    out_read_data
);
  import owm_pkg::*;

  cfg_t cfg_r;
  res_t res_new;
  res_t out_r;
  res_t skid_r;
  logic out_vld_r;
  logic skid_vld_r;
  logic in_acc;
  logic out_take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.reset_low_ticks       <= RST_RESET_LOW;
      cfg_r.presence_window_ticks <= RST_PRES_WINDOW;
      cfg_r.post_reset_ticks      <= RST_POST_RESET;
      cfg_r.slot_low_ticks        <= RST_SLOT_LOW;
      cfg_r.sample_delay_ticks    <= RST_SAMPLE_DELAY;
      cfg_r.slot_length_ticks     <= RST_SLOT_LENGTH;
      cfg_r.recovery_ticks        <= RST_RECOVERY;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_RESET_LOW:    cfg_r.reset_low_ticks       <= cfg_wdata;
        CFG_PRES_WINDOW:  cfg_r.presence_window_ticks <= cfg_wdata;
        CFG_POST_RESET:   cfg_r.post_reset_ticks      <= cfg_wdata;
        CFG_SLOT_LOW:     cfg_r.slot_low_ticks        <= cfg_wdata[7:0];
        CFG_SAMPLE_DELAY: cfg_r.sample_delay_ticks    <= cfg_wdata[7:0];
        CFG_SLOT_LENGTH:  cfg_r.slot_length_ticks     <= cfg_wdata[7:0];
        CFG_RECOVERY:     cfg_r.recovery_ticks        <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  assign in_stall = skid_vld_r;
  assign in_acc   = in_valid && !skid_vld_r;
  assign out_take = out_vld_r && !out_stall;

  owm_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (in_acc),
    .start_req   (in_start_req),
    .operation   (in_operation),
    .write_data  (in_write_data),
    .line_sample (in_line_sample),
    .cfg         (cfg_r),
    .res         (res_new)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (out_take) begin
      if (skid_vld_r) begin
        out_r      <= skid_r;
        skid_vld_r <= 1'b0;
      end else if (in_acc) begin
        out_r <= res_new;
      end else begin
        out_vld_r <= 1'b0;
      end
    end else if (in_acc) begin
      if (!out_vld_r) begin
        out_r     <= res_new;
        out_vld_r <= 1'b1;
      end else begin
        skid_r     <= res_new;
        skid_vld_r <= 1'b1;
      end
    end
  end

  assign out_valid     = out_vld_r;
  assign out_drive_low = out_r.drive_low;
  assign out_busy_res  = out_r.busy_res;
  assign out_done_res  = out_r.done_res;
  assign out_presence  = out_r.presence;
  assign out_read_data = out_r.read_data;

endmodule

FILE: src/owm_checker.sv
// ----------------------------------------------------------------------------
// One-wire bus master checker
// Port-level properties of the one-wire bus master, bound to the top level.
// ----------------------------------------------------------------------------
`include "one_wire_bus_master_unit_defines.svh"

module owm_checker (
  input logic clk,
  input logic rst_n,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input logic out_drive_low,
  input logic out_busy_res,
  input logic out_done_res
);

  `OWM_ASSERT_SAME(a_done_busy, clk, rst_n, out_valid && out_done_res, out_busy_res)
  `OWM_ASSERT_SAME(a_drive_busy, clk, rst_n, out_valid && out_drive_low, out_busy_res)
  `OWM_ASSERT_SAME(a_stall_full, clk, rst_n, in_stall, out_valid)
  `OWM_ASSERT_NEXT(a_hold_valid, clk, rst_n, out_valid && out_stall, out_valid)
  `OWM_ASSERT_NEXT_ALWAYS(a_reset_empty, clk, !rst_n, !out_valid && !in_stall)

endmodule

bind one_wire_bus_master_unit owm_checker u_owm_checker (.*);

FILE: bench/tb_top.sv
// ----------------------------------------------------------------------------
// One-wire bus master testbench
// Sends bus ticks through the valid/stall input channel and compares every
// result transfer with a bench model of the master or a table row. One write
// under the power-on timing comes first, then a short table of hand-picked
// ticks. Random reset, write and read operations follow under a series of
// timing settings, ending with a short run under fixed timing and no idling.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import owm_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam int LINE_NOISE  = 0;
  localparam int LINE_HIGH   = 1;
  localparam int LINE_SPARSE = 2;

  localparam res_t QUIET = '0;

  typedef struct {
    logic       start;
    logic [1:0] op;
    logic [7:0] wd;
    logic       line;
    logic       typed;
    res_t       want;
  } plan_row_t;

  logic                clk;
  logic                rst_n;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [CfgDataW-1:0] cfg_wdata;
  logic                in_valid;
  logic                in_stall;
  logic                in_start_req;
  logic [1:0]          in_operation;
  logic [7:0]          in_write_data;
  logic                in_line_sample;
  logic                out_valid;
  logic                out_stall;
  logic                out_drive_low;
  logic                out_busy_res;
  logic                out_done_res;
  logic                out_presence;
  logic [7:0]          out_read_data;

  // Model of the master: timing registers and sequencer state.
  cfg_t        timing_regs;
  logic [2:0]  bus_phase;
  logic [1:0]  bus_op;
  int unsigned tick_cnt;
  logic [3:0]  bits_sent;
  logic [7:0]  shift_reg;
  logic        presence_flag;
  logic [7:0]  read_byte;

  res_t bus_results_due[$];
  logic row_typed;
  res_t row_want;
  logic gaps_on;

  int ticks_sent;
  int results_seen;
  int ops_started;
  int settings_used;
  int mismatches;

  plan_row_t plan [27] = '{
    '{1'b0, OP_RESET,  8'h00, 1'b1, 1'b1, QUIET},
    '{1'b1, OP_UNUSED, 8'hFF, 1'b0, 1'b1, QUIET},
    '{1'b1, OP_RESET,  8'h00, 1'b1, 1'b0, QUIET},
    '{1'b0, OP_RESET,  8'h00, 1'b1, 1'b1, '{1'b1, 1'b1, 1'b0, 1'b0, 8'h00}},
    '{1'b0, OP_RESET,  8'h00, 1'b0, 1'b1, '{1'b0, 1'b1, 1'b1, 1'b1, 8'h00}},
    '{1'b1, OP_RESET,  8'h00, 1'b1, 1'b0, QUIET},
    '{1'b0, OP_RESET,  8'h00, 1'b0, 1'b0, QUIET},
    '{1'b0, OP_RESET,  8'h00, 1'b1, 1'b0, QUIET},
    '{1'b1, OP_WRITE,  8'hFF, 1'b1, 1'b0, QUIET},
    '{1'b1, OP_READ,   8'h00, 1'b0, 1'b0, QUIET},
    '{1'b0, OP_WRITE,  8'h00, 1'b1, 1'b0, QUIET},
    '{1'b1, OP_RESET,  8'hFF, 1'b0, 1'b0, QUIET},
    '{1'b0, OP_READ,   8'h00, 1'b1, 1'b0, QUIET},
    '{1'b1, OP_WRITE,  8'h5A, 1'b0, 1'b0, QUIET},
    '{1'b0, OP_RESET,  8'h00, 1'b1, 1'b0, QUIET},
    '{1'b1, OP_UNUSED, 8'hA5, 1'b0, 1'b0, QUIET},
    '{1'b0, OP_RESET,  8'h00, 1'b1, 1'b0, QUIET},
    '{1'b1, OP_READ,   8'h00, 1'b0, 1'b0, QUIET},
    '{1'b0, OP_RESET,  8'h00, 1'b1, 1'b0, QUIET},
    '{1'b0, OP_RESET,  8'h00, 1'b0, 1'b0, QUIET},
    '{1'b0, OP_RESET,  8'h00, 1'b1, 1'b0, QUIET},
    '{1'b0, OP_RESET,  8'h00, 1'b1, 1'b0, QUIET},
    '{1'b0, OP_RESET,  8'h00, 1'b0, 1'b0, QUIET},
    '{1'b0, OP_RESET,  8'h00, 1'b0, 1'b0, QUIET},
    '{1'b0, OP_RESET,  8'h00, 1'b1, 1'b0, QUIET},
    '{1'b0, OP_RESET,  8'h00, 1'b0, 1'b0, QUIET},
    '{1'b0, OP_RESET,  8'h00, 1'b1, 1'b1, '{1'b0, 1'b0, 1'b0, 1'b0, 8'h4D}}
  };

  one_wire_bus_master_unit uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_start_req   (in_start_req),
    .in_operation   (in_operation),
    .in_write_data  (in_write_data),
    .in_line_sample (in_line_sample),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_drive_low  (out_drive_low),
    .out_busy_res   (out_busy_res),
    .out_done_res   (out_done_res),
    .out_presence   (out_presence),
    .out_read_data  (out_read_data)
  );

  always #5 clk = ~clk;

  function automatic int unsigned floor_one(input int unsigned v);
    return (v == 0) ? 1 : v;
  endfunction

  // Advances the model by one tick and returns the status seen on that tick.
  function automatic res_t bus_tick(input logic start, input logic [1:0] op,
                                    input logic [7:0] wd, input logic line);
    res_t        r;
    int unsigned nxt;
    int unsigned len;
    int unsigned low;
    int unsigned spot;
    r = '0;
    nxt = tick_cnt + 1;
    case (bus_phase)
      PH_IDLE: begin
        if (start && op == OP_RESET) begin
          bus_op = op;
          presence_flag = 1'b0;
          tick_cnt = 0;
          bus_phase = PH_RST_LOW;
        end else if (start && (op == OP_WRITE || op == OP_READ)) begin
          bus_op = op;
          shift_reg = (op == OP_WRITE) ? wd : 8'h00;
          bits_sent = '0;
          tick_cnt = 0;
          bus_phase = PH_SLOT;
        end
      end
      PH_RST_LOW: begin
        r.drive_low = 1'b1;
        r.busy_res = 1'b1;
        if (nxt >= floor_one(32'(timing_regs.reset_low_ticks))) begin
          tick_cnt = 0;
          bus_phase = PH_RST_WIN;
        end else begin
          tick_cnt = nxt;
        end
      end
      PH_RST_WIN: begin
        r.busy_res = 1'b1;
        if (!line) presence_flag = 1'b1;
        if (nxt >= floor_one(32'(timing_regs.presence_window_ticks))) begin
          tick_cnt = 0;
          if (timing_regs.post_reset_ticks == 16'd0) begin
            bus_phase = PH_IDLE;
            r.done_res = 1'b1;
          end else begin
            bus_phase = PH_RST_REC;
          end
        end else begin
          tick_cnt = nxt;
        end
      end
      PH_RST_REC: begin
        r.busy_res = 1'b1;
        if (nxt >= 32'(timing_regs.post_reset_ticks)) begin
          tick_cnt = 0;
          bus_phase = PH_IDLE;
          r.done_res = 1'b1;
        end else begin
          tick_cnt = nxt;
        end
      end
      PH_SLOT: begin
        len = floor_one(32'(timing_regs.slot_length_ticks));
        low = floor_one(32'(timing_regs.slot_low_ticks));
        r.busy_res = 1'b1;
        r.drive_low = (tick_cnt < low) || (bus_op == OP_WRITE && !shift_reg[0]);
        if (bus_op == OP_READ) begin
          spot = low + 32'(timing_regs.sample_delay_ticks);
          if (spot > len - 1) spot = len - 1;
          if (tick_cnt == spot) shift_reg = {line, shift_reg[7:1]};
        end
        if (nxt >= len) begin
          if (bus_op == OP_WRITE) shift_reg = shift_reg >> 1;
          bits_sent = bits_sent + 4'd1;
          tick_cnt = 0;
          if (bits_sent >= 4'(BitsPerByte)) begin
            if (bus_op == OP_READ) read_byte = shift_reg;
            bus_phase = PH_IDLE;
            r.done_res = 1'b1;
          end else if (timing_regs.recovery_ticks != 8'd0) begin
            bus_phase = PH_SLOT_REC;
          end
        end else begin
          tick_cnt = nxt;
        end
      end
      PH_SLOT_REC: begin
        r.busy_res = 1'b1;
        if (nxt >= 32'(timing_regs.recovery_ticks)) begin
          tick_cnt = 0;
          bus_phase = PH_SLOT;
        end else begin
          tick_cnt = nxt;
        end
      end
      default: begin
        bus_phase = PH_IDLE;
        tick_cnt = 0;
      end
    endcase
    r.presence = presence_flag;
    r.read_data = read_byte;
    return r;
  endfunction

  function automatic logic line_level(input int mode);
    if (mode == LINE_HIGH) return 1'b1;
    if (mode == LINE_SPARSE) return $urandom_range(0, 9) != 0;
    return 1'($urandom_range(0, 1));
  endfunction

  task automatic report_mismatch(input string msg);
    $display("tb_top: mismatch at %0t: %s", $realtime, msg);
    mismatches++;
  endtask

  task automatic check_result(input res_t got);
    res_t want;
    if (bus_results_due.size() == 0) begin
      report_mismatch($sformatf("result %h arrived with nothing expected", got));
    end else begin
      want = bus_results_due.pop_front();
      if (got.drive_low !== want.drive_low)
        report_mismatch($sformatf("result %0d drive_low %b, expected %b",
                                  results_seen, got.drive_low, want.drive_low));
      if (got.busy_res !== want.busy_res)
        report_mismatch($sformatf("result %0d busy %b, expected %b",
                                  results_seen, got.busy_res, want.busy_res));
      if (got.done_res !== want.done_res)
        report_mismatch($sformatf("result %0d done %b, expected %b",
                                  results_seen, got.done_res, want.done_res));
      if (got.presence !== want.presence)
        report_mismatch($sformatf("result %0d presence %b, expected %b",
                                  results_seen, got.presence, want.presence));
      if (got.read_data !== want.read_data)
        report_mismatch($sformatf("result %0d read_data %h, expected %h",
                                  results_seen, got.read_data, want.read_data));
    end
    results_seen++;
  endtask

  // Every accepted tick steps the model; every accepted result is checked.
  always @(posedge clk) begin
    res_t predicted;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        predicted = bus_tick(in_start_req, in_operation, in_write_data, in_line_sample);
        bus_results_due.push_back(row_typed ? row_want : predicted);
        ticks_sent++;
      end
      if (out_valid && !out_stall)
        check_result({out_drive_low, out_busy_res, out_done_res, out_presence,
                      out_read_data});
    end
  end

  always begin
    @(negedge clk);
    if (rst_n && gaps_on && $urandom_range(0, 9) == 0) begin
      out_stall <= 1'b1;
      repeat ($urandom_range(1, 17)) @(negedge clk);
      out_stall <= 1'b0;
    end
  end

  task automatic send_tick(input logic start, input logic [1:0] op, input logic [7:0] wd,
                           input logic line, input logic typed = 1'b0,
                           input res_t want = '0);
    if (gaps_on && $urandom_range(0, 9) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_start_req   <= start;
    in_operation   <= op;
    in_write_data  <= wd;
    in_line_sample <= line;
    row_typed      <= typed;
    row_want       <= want;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic run_op(input logic [1:0] op, input int line_mode);
    send_tick(1'b1, op, 8'($urandom_range(0, 255)), line_level(line_mode));
    ops_started++;
    while (bus_phase != PH_IDLE)
      send_tick($urandom_range(0, 3) == 0, 2'($urandom_range(0, 3)),
                8'($urandom_range(0, 255)), line_level(line_mode));
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (bus_results_due.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [15:0] v);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    case (idx)
      CFG_RESET_LOW:    timing_regs.reset_low_ticks = v;
      CFG_PRES_WINDOW:  timing_regs.presence_window_ticks = v;
      CFG_POST_RESET:   timing_regs.post_reset_ticks = v;
      CFG_SLOT_LOW:     timing_regs.slot_low_ticks = v[7:0];
      CFG_SAMPLE_DELAY: timing_regs.sample_delay_ticks = v[7:0];
      CFG_SLOT_LENGTH:  timing_regs.slot_length_ticks = v[7:0];
      CFG_RECOVERY:     timing_regs.recovery_ticks = v[7:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  // The byte-wide registers get random upper bits, which must be ignored.
  task automatic set_timing(input logic [15:0] rl, input logic [15:0] pw,
                            input logic [15:0] pr, input logic [7:0] sl,
                            input logic [7:0] sd, input logic [7:0] sn,
                            input logic [7:0] rc);
    settle();
    write_reg(CFG_RESET_LOW, rl);
    write_reg(CFG_PRES_WINDOW, pw);
    write_reg(CFG_POST_RESET, pr);
    write_reg(CFG_SLOT_LOW, {8'($urandom), sl});
    write_reg(CFG_SAMPLE_DELAY, {8'($urandom), sd});
    write_reg(CFG_SLOT_LENGTH, {8'($urandom), sn});
    write_reg(CFG_RECOVERY, {8'($urandom), rc});
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  initial begin
    #40ms;
    $display("tb_top NOT OK");
    $finish;
  end

  initial begin
    int          target;
    int          phase_end;
    int unsigned pick;
    logic [1:0]  op;
    clk = 1'b0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_valid = 1'b0;
    in_start_req = 1'b0;
    in_operation = OP_RESET;
    in_write_data = '0;
    in_line_sample = 1'b1;
    out_stall = 1'b0;
    row_typed = 1'b0;
    row_want = QUIET;
    gaps_on = 1'b1;
    timing_regs = '{16'd500, 16'd240, 16'd500, 8'd1, 8'd6, 8'd65, 8'd2};
    bus_phase = PH_IDLE;
    bus_op = OP_RESET;
    tick_cnt = 0;
    bits_sent = '0;
    shift_reg = '0;
    presence_flag = 1'b0;
    read_byte = '0;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // One byte under the power-on timing, before any register is written.
    run_op(OP_WRITE, LINE_NOISE);

    // Zero timings, all treated as one or skipped, and a clamped sample point.
    set_timing(16'd0, 16'd0, 16'd0, 8'd0, 8'd255, 8'd0, 8'd0);
    foreach (plan[i])
      send_tick(plan[i].start, plan[i].op, plan[i].wd, plan[i].line, plan[i].typed,
                plan[i].want);

    target = 1800;
    for (int k = 0; ticks_sent < target; k++) begin
      if (k % 4 == 3)
        set_timing(16'($urandom_range(30, 150)), 16'($urandom_range(20, 80)),
                   16'($urandom_range(0, 100)), 8'($urandom_range(1, 8)),
                   8'($urandom_range(0, 30)), 8'($urandom_range(20, 40)),
                   8'($urandom_range(0, 6)));
      else
        set_timing(16'($urandom_range(0, 12)), 16'($urandom_range(0, 12)),
                   16'($urandom_range(0, 10)), 8'($urandom_range(0, 6)),
                   8'($urandom_range(0, 12)), 8'($urandom_range(0, 20)),
                   8'($urandom_range(0, 5)));
      gaps_on <= $urandom_range(0, 4) != 0;
      phase_end = ticks_sent + 250;
      while (ticks_sent < phase_end && ticks_sent < target) begin
        pick = $urandom_range(0, 19);
        op = (pick == 0) ? OP_UNUSED : (pick < 7) ? OP_RESET : (pick < 13) ? OP_WRITE : OP_READ;
        run_op(op, $urandom_range(LINE_NOISE, LINE_SPARSE));
        if ($urandom_range(0, 3) == 0)
          repeat ($urandom_range(1, 3))
            send_tick(1'b0, 2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                      1'($urandom_range(0, 1)));
      end
    end

    // Fixed short timings, run without any idling.
    set_timing(16'd3, 16'd4, 16'd2, 8'd2, 8'd1, 8'd6, 8'd1);
    gaps_on <= 1'b0;
    run_op(OP_RESET, LINE_SPARSE);
    run_op(OP_WRITE, LINE_NOISE);
    run_op(OP_READ, LINE_NOISE);
    settle();

    $display("tb_top: %0d ticks, %0d operations, %0d timing settings", ticks_sent,
             ops_started, settings_used);
    $display("tb_top: %0d results compared, %0d mismatches", results_seen, mismatches);
    if (mismatches == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
